[hw/rtl/rv64m_multiply_divide_unit_macros.svh]
// Assertion macros for the RV64M multiply/divide unit.
// Included by the modules that carry assertions; no other dependencies.
`ifndef RV64M_MULTIPLY_DIVIDE_UNIT_MACROS_SVH
`define RV64M_MULTIPLY_DIVIDE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define MDU_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define MDU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MDU_ASSERT(lbl, clk, rstn, prop, msg)
`define MDU_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

[hw/rtl/rv64m_mdu_pkg.sv]
// Shared types, constants and helpers for the RV64M multiply/divide unit.
// No dependencies.
`timescale 1ns / 1ps
package rv64m_mdu_pkg;

    localparam int XLEN_DEF   = 64;
    localparam int DATA_W     = 64;
    localparam int FUNC_W     = 3;
    localparam int S_TDATA_W  = 136;
    localparam int M_TDATA_W  = 64;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_MUL    = 3'd0,
        FUNC_MULH   = 3'd1,
        FUNC_MULHSU = 3'd2,
        FUNC_MULHU  = 3'd3,
        FUNC_DIV    = 3'd4,
        FUNC_DIVU   = 3'd5,
        FUNC_REM    = 3'd6,
        FUNC_REMU   = 3'd7
    } func_t;

    typedef struct packed {
        logic  valid;
        func_t func;
        logic  neg;
    } ctrl_t;

    function automatic logic func_is_div(input func_t f);
        return (f == FUNC_DIV) || (f == FUNC_DIVU) || (f == FUNC_REM) || (f == FUNC_REMU);
    endfunction

    function automatic logic func_is_rem(input func_t f);
        return (f == FUNC_REM) || (f == FUNC_REMU);
    endfunction

    function automatic logic func_is_sdiv(input func_t f);
        return (f == FUNC_DIV) || (f == FUNC_REM);
    endfunction

endpackage

[hw/rtl/rv64m_mdu_front.sv]
// Front stages: partial products, product sum, high-word sign correction,
// divide operand preparation. Depends on rv64m_mdu_pkg and the macro header.
`timescale 1ns / 1ps
`include "rv64m_multiply_divide_unit_macros.svh"
module rv64m_mdu_front #(
    parameter int XLEN = rv64m_mdu_pkg::XLEN_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  rv64m_mdu_pkg::func_t  in_func,
    input  logic [XLEN-1:0]       in_a,
    input  logic [XLEN-1:0]       in_b,
    output rv64m_mdu_pkg::ctrl_t  out_ctrl,
    output logic [XLEN-1:0]       out_quo,
    output logic [XLEN-1:0]       out_div
);
    localparam int LW = XLEN / 2;
    localparam int UW = XLEN - LW;
    localparam int PW = 2 * XLEN;

    // stage 1
    logic                 s1_valid_reg;
    rv64m_mdu_pkg::func_t s1_func_reg;
    logic [XLEN-1:0]      s1_a_reg, s1_b_reg, s1_abs_a_reg, s1_abs_b_reg;
    logic [XLEN-1:0]      s1_abs_a_next, s1_abs_b_next;
    logic                 s1_bz_reg;
    logic [2*LW-1:0]      s1_p00_reg;
    logic [LW+UW-1:0]     s1_p01_reg, s1_p10_reg;
    logic [2*UW-1:0]      s1_p11_reg;

    // stage 2
    logic                 s2_valid_reg;
    rv64m_mdu_pkg::func_t s2_func_reg;
    logic [XLEN-1:0]      s2_a_reg, s2_b_reg, s2_abs_a_reg, s2_abs_b_reg;
    logic                 s2_bz_reg;
    logic [PW-1:0]        s2_prod_reg, s2_prod_next;

    // stage 3
    rv64m_mdu_pkg::ctrl_t s3_ctrl_reg, s3_ctrl_next;
    logic [XLEN-1:0]      s3_quo_reg, s3_quo_next, s3_div_reg, s3_div_next;

    logic na2, nb2;
    logic [XLEN-1:0] hi2;

    always_comb begin
        s1_abs_a_next = (rv64m_mdu_pkg::func_is_sdiv(in_func) && in_a[XLEN-1]) ? -in_a : in_a;
        s1_abs_b_next = (rv64m_mdu_pkg::func_is_sdiv(in_func) && in_b[XLEN-1]) ? -in_b : in_b;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= in_valid;
        end
        if (en) begin
            s1_func_reg  <= in_func;
            s1_a_reg     <= in_a;
            s1_b_reg     <= in_b;
            s1_abs_a_reg <= s1_abs_a_next;
            s1_abs_b_reg <= s1_abs_b_next;
            s1_bz_reg    <= (in_b == '0);
            s1_p00_reg   <= in_a[LW-1:0] * in_b[LW-1:0];
            s1_p01_reg   <= (LW+UW)'(in_a[LW-1:0]) * (LW+UW)'(in_b[XLEN-1:LW]);
            s1_p10_reg   <= (LW+UW)'(in_a[XLEN-1:LW]) * (LW+UW)'(in_b[LW-1:0]);
            s1_p11_reg   <= in_a[XLEN-1:LW] * in_b[XLEN-1:LW];
        end
    end

    always_comb begin
        s2_prod_next = PW'(s1_p00_reg)
                     + (PW'(s1_p01_reg) << LW)
                     + (PW'(s1_p10_reg) << LW)
                     + (PW'(s1_p11_reg) << (2 * LW));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (en) begin
            s2_valid_reg <= s1_valid_reg;
        end
        if (en) begin
            s2_func_reg  <= s1_func_reg;
            s2_a_reg     <= s1_a_reg;
            s2_b_reg     <= s1_b_reg;
            s2_abs_a_reg <= s1_abs_a_reg;
            s2_abs_b_reg <= s1_abs_b_reg;
            s2_bz_reg    <= s1_bz_reg;
            s2_prod_reg  <= s2_prod_next;
        end
    end

    always_comb begin
        na2 = s2_a_reg[XLEN-1];
        nb2 = s2_b_reg[XLEN-1];
        hi2 = s2_prod_reg[PW-1:XLEN];
        s3_ctrl_next.valid = s2_valid_reg;
        s3_ctrl_next.func  = s2_func_reg;
        s3_ctrl_next.neg   = 1'b0;
        s3_quo_next        = '0;
        s3_div_next        = '0;
        case (s2_func_reg)
            rv64m_mdu_pkg::FUNC_MUL: begin
                s3_quo_next = s2_prod_reg[XLEN-1:0];
            end
            rv64m_mdu_pkg::FUNC_MULH: begin
                s3_quo_next = hi2 - (na2 ? s2_b_reg : '0) - (nb2 ? s2_a_reg : '0);
            end
            rv64m_mdu_pkg::FUNC_MULHSU: begin
                s3_quo_next = hi2 - (na2 ? s2_b_reg : '0);
            end
            rv64m_mdu_pkg::FUNC_MULHU: begin
                s3_quo_next = hi2;
            end
            rv64m_mdu_pkg::FUNC_DIV: begin
                s3_quo_next      = s2_abs_a_reg;
                s3_div_next      = s2_abs_b_reg;
                s3_ctrl_next.neg = !s2_bz_reg && (na2 != nb2);
            end
            rv64m_mdu_pkg::FUNC_REM: begin
                s3_quo_next      = s2_abs_a_reg;
                s3_div_next      = s2_abs_b_reg;
                s3_ctrl_next.neg = na2;
            end
            default: begin
                s3_quo_next = s2_abs_a_reg;
                s3_div_next = s2_abs_b_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_ctrl_reg.valid <= 1'b0;
        end else if (en) begin
            s3_ctrl_reg.valid <= s3_ctrl_next.valid;
        end
        if (en) begin
            s3_ctrl_reg.func <= s3_ctrl_next.func;
            s3_ctrl_reg.neg  <= s3_ctrl_next.neg;
            s3_quo_reg       <= s3_quo_next;
            s3_div_reg       <= s3_div_next;
        end
    end

    assign out_ctrl = s3_ctrl_reg;
    assign out_quo  = s3_quo_reg;
    assign out_div  = s3_div_reg;

    `MDU_ASSERT(a_s1_take, aclk, aresetn, en && in_valid |=> s1_valid_reg, "beat lost at entry")
    `MDU_ASSERT(a_unsigned_pos, aclk, aresetn,
        s3_ctrl_reg.valid && (s3_ctrl_reg.func == rv64m_mdu_pkg::FUNC_DIVU ||
        s3_ctrl_reg.func == rv64m_mdu_pkg::FUNC_REMU) |-> !s3_ctrl_reg.neg,
        "unsigned divide marked for negation")
endmodule

[hw/rtl/rv64m_mdu_div_stage.sv]
// One restoring-division step: one quotient bit per stage, multiplies pass.
// Depends on rv64m_mdu_pkg and the macro header.
`timescale 1ns / 1ps
`include "rv64m_multiply_divide_unit_macros.svh"
module rv64m_mdu_div_stage #(
    parameter int XLEN = rv64m_mdu_pkg::XLEN_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  rv64m_mdu_pkg::ctrl_t in_ctrl,
    input  logic [XLEN-1:0]      in_rem,
    input  logic [XLEN-1:0]      in_quo,
    input  logic [XLEN-1:0]      in_div,
    output rv64m_mdu_pkg::ctrl_t out_ctrl,
    output logic [XLEN-1:0]      out_rem,
    output logic [XLEN-1:0]      out_quo,
    output logic [XLEN-1:0]      out_div
);
    rv64m_mdu_pkg::ctrl_t ctrl_reg;
    logic [XLEN-1:0] rem_reg, rem_next, quo_reg, quo_next, div_reg;
    logic [XLEN:0]   trial, diff;
    logic            ge;

    always_comb begin
        trial    = {in_rem, in_quo[XLEN-1]};
        diff     = trial - {1'b0, in_div};
        ge       = trial >= {1'b0, in_div};
        rem_next = in_rem;
        quo_next = in_quo;
        if (rv64m_mdu_pkg::func_is_div(in_ctrl.func)) begin
            rem_next = ge ? diff[XLEN-1:0] : trial[XLEN-1:0];
            quo_next = {in_quo[XLEN-2:0], ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg.valid <= 1'b0;
        end else if (en) begin
            ctrl_reg.valid <= in_ctrl.valid;
        end
        if (en) begin
            ctrl_reg.func <= in_ctrl.func;
            ctrl_reg.neg  <= in_ctrl.neg;
            rem_reg       <= rem_next;
            quo_reg       <= quo_next;
            div_reg       <= in_div;
        end
    end

    assign out_ctrl = ctrl_reg;
    assign out_rem  = rem_reg;
    assign out_quo  = quo_reg;
    assign out_div  = div_reg;

    `MDU_ASSERT(a_rem_bound, aclk, aresetn,
        ctrl_reg.valid && rv64m_mdu_pkg::func_is_div(ctrl_reg.func) && div_reg != '0
        |-> rem_reg < div_reg, "partial remainder not below divisor")
endmodule

[hw/rtl/rv64m_multiply_divide_unit.sv]
// Channel  Dir  Fields (tdata, low bit first)
// s_       in   func[2:0], operand_a[66:3], operand_b[130:67]
// m_       out  result[63:0]
// One beat accepted per cycle unless the output is stalled.
// Every operation, multiplies included, passes the radix-2 divider chain, one quotient bit per stage.
// Reset (aresetn low, synchronous) clears only the valid bits.
// A stalled output freezes the whole pipeline; s_tready follows it.
// Depends on rv64m_mdu_pkg, rv64m_mdu_front and rv64m_mdu_div_stage.
`timescale 1ns / 1ps
module rv64m_multiply_divide_unit #(
    parameter int XLEN = rv64m_mdu_pkg::XLEN_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [rv64m_mdu_pkg::S_TDATA_W-1:0]   s_tdata,  // func, operand_a, operand_b
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [rv64m_mdu_pkg::M_TDATA_W-1:0]   m_tdata   // result
);
    localparam int DW = rv64m_mdu_pkg::DATA_W;

    logic en;
    logic m_valid_reg;
    logic [rv64m_mdu_pkg::M_TDATA_W-1:0] m_data_reg, m_data_next;
    logic [XLEN-1:0] sel;

    rv64m_mdu_pkg::ctrl_t stg_ctrl [0:XLEN];
    logic [XLEN-1:0] stg_rem [0:XLEN];
    logic [XLEN-1:0] stg_quo [0:XLEN];
    logic [XLEN-1:0] stg_div [0:XLEN];

    assign en       = !m_valid_reg || m_tready;
    assign s_tready = en;

    rv64m_mdu_front #(.XLEN(XLEN)) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_tvalid),
        .in_func  (rv64m_mdu_pkg::func_t'(s_tdata[2:0])),
        .in_a     (s_tdata[3 +: XLEN]),
        .in_b     (s_tdata[3 + DW +: XLEN]),
        .out_ctrl (stg_ctrl[0]),
        .out_quo  (stg_quo[0]),
        .out_div  (stg_div[0])
    );
    assign stg_rem[0] = '0;

    for (genvar i = 0; i < XLEN; i++) begin : g_div
        rv64m_mdu_div_stage #(.XLEN(XLEN)) u_stage (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .in_ctrl  (stg_ctrl[i]),
            .in_rem   (stg_rem[i]),
            .in_quo   (stg_quo[i]),
            .in_div   (stg_div[i]),
            .out_ctrl (stg_ctrl[i+1]),
            .out_rem  (stg_rem[i+1]),
            .out_quo  (stg_quo[i+1]),
            .out_div  (stg_div[i+1])
        );
    end

    always_comb begin
        sel = rv64m_mdu_pkg::func_is_rem(stg_ctrl[XLEN].func) ? stg_rem[XLEN] : stg_quo[XLEN];
        if (stg_ctrl[XLEN].neg) begin
            sel = -sel;
        end
        m_data_next = rv64m_mdu_pkg::M_TDATA_W'(sel);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= stg_ctrl[XLEN].valid;
        end
        if (en && stg_ctrl[XLEN].valid) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
endmodule
